// ===== design/ihsp_pkg.sv =====
// Shared types, constants and helper functions for the image header size parser.
package ihsp_pkg;

	localparam int JPEG_WINDOW_BYTES = 65536;
	localparam int POS_W             = $clog2(JPEG_WINDOW_BYTES + 1);
	localparam int OUT_FIELDS_W      = 2 + 32 + 32;
	localparam int OUT_TDATA_W       = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [7:0] BYTE_PNG_LEAD  = 8'h89;
	localparam logic [7:0] BYTE_MARK      = 8'hFF;
	localparam logic [7:0] BYTE_SOI       = 8'hD8;
	localparam logic [7:0] BYTE_SOF_LO    = 8'hC0;
	localparam logic [7:0] BYTE_SOF_HI    = 8'hCF;
	localparam logic [7:0] BYTE_DHT       = 8'hC4;
	localparam logic [7:0] BYTE_JPG       = 8'hC8;
	localparam logic [7:0] BYTE_DAC       = 8'hCC;
	localparam logic [7:0] BYTE_RST_LO    = 8'hD0;
	localparam logic [7:0] BYTE_SOS       = 8'hDA;
	localparam logic [7:0] BYTE_TEM       = 8'h01;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_PNG  = 2'd1,
		KIND_JPEG = 2'd2
	} image_kind_t;

	typedef enum logic [3:0] {
		MODE_DETECT  = 4'd0,
		MODE_PNG     = 4'd1,
		MODE_JPEG_D8 = 4'd2,
		MODE_FF      = 4'd3,
		MODE_CODE    = 4'd4,
		MODE_LENHI   = 4'd5,
		MODE_LENLO   = 4'd6,
		MODE_SKIP    = 4'd7,
		MODE_SOF     = 4'd8
	} parse_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        valid;
		image_kind_t image_kind;
		logic [31:0] width;
		logic [31:0] height;
	} result_t;

	function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0: b = 8'h89;
			3'd1: b = 8'h50;
			3'd2: b = 8'h4E;
			3'd3: b = 8'h47;
			3'd4: b = 8'h0D;
			3'd5: b = 8'h0A;
			3'd6: b = 8'h1A;
			default: b = 8'h0A;
		endcase
		return b;
	endfunction

	function automatic logic is_sof(input logic [7:0] m);
		return (m >= BYTE_SOF_LO) && (m <= BYTE_SOF_HI) &&
			(m != BYTE_DHT) && (m != BYTE_JPG) && (m != BYTE_DAC);
	endfunction

	function automatic logic is_standalone(input logic [7:0] m);
		return ((m >= BYTE_RST_LO) && (m <= BYTE_SOS)) || (m == BYTE_TEM);
	endfunction

endpackage

// ===== design/ihsp_in_reg.sv =====
// Input register stage: holds one accepted byte item for the parser.
module ihsp_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ihsp_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output ihsp_pkg::in_item_t item_s1
);
	import ihsp_pkg::*;

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

// ===== design/ihsp_parser.sv =====
// Parser state and the per-byte step for PNG and JPEG headers.
module ihsp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  ihsp_pkg::in_item_t item,
	output ihsp_pkg::result_t  result
);
	import ihsp_pkg::*;

	localparam logic [POS_W-1:0] WINDOW_POS = POS_W'(JPEG_WINDOW_BYTES);

	logic [POS_W-1:0] pos_q, pos_d;
	parse_mode_t      mode_q, mode_d;
	logic [15:0]      skip_q, skip_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [31:0]      width_q, width_d;
	logic [31:0]      height_q, height_d;
	logic [3:0]       field_q, field_d;
	logic             decided_q, decided_d;

	logic        emit_p;
	image_kind_t kind_p;
	logic [31:0] w_p, h_p;
	logic [15:0] len;
	logic [7:0]  b;

	assign b   = item.data_byte;
	assign len = {len_hi_q, b};

	// one step of the header walk
	always_comb begin
		mode_d   = mode_q;
		skip_d   = skip_q;
		len_hi_d = len_hi_q;
		width_d  = width_q;
		height_d = height_q;
		field_d  = field_q;
		emit_p   = 1'b0;
		kind_p   = KIND_NONE;
		w_p      = '0;
		h_p      = '0;
		if (!decided_q) begin
			if (mode_q != MODE_DETECT && mode_q != MODE_PNG && pos_q >= WINDOW_POS) begin
				emit_p = 1'b1;
			end else begin
				unique case (mode_q)
					MODE_DETECT: begin
						if (b == BYTE_PNG_LEAD) mode_d = MODE_PNG;
						else if (b == BYTE_MARK) mode_d = MODE_JPEG_D8;
						else emit_p = 1'b1;
					end
					MODE_PNG: begin
						if (pos_q < POS_W'(8)) begin
							if (b != png_sig_byte(pos_q[2:0])) emit_p = 1'b1;
						end else if (pos_q >= POS_W'(16) && pos_q < POS_W'(20)) begin
							width_d = {width_q[23:0], b};
						end else if (pos_q >= POS_W'(20) && pos_q < POS_W'(24)) begin
							height_d = {height_q[23:0], b};
							if (pos_q == POS_W'(23)) begin
								emit_p = 1'b1;
								kind_p = KIND_PNG;
								w_p    = width_q;
								h_p    = height_d;
							end
						end
					end
					MODE_JPEG_D8: begin
						if (b != BYTE_SOI) emit_p = 1'b1;
						else mode_d = MODE_FF;
					end
					MODE_FF: begin
						if (b != BYTE_MARK) emit_p = 1'b1;
						else mode_d = MODE_CODE;
					end
					MODE_CODE: begin
						if (is_sof(b)) begin
							mode_d  = MODE_SOF;
							field_d = '0;
						end else if (is_standalone(b)) begin
							mode_d = MODE_FF;
						end else begin
							mode_d = MODE_LENHI;
						end
					end
					MODE_LENHI: begin
						len_hi_d = b;
						mode_d   = MODE_LENLO;
					end
					MODE_LENLO: begin
						if (len < 16'd2) begin
							emit_p = 1'b1;
						end else begin
							skip_d = len - 16'd2;
							mode_d = (skip_d == '0) ? MODE_FF : MODE_SKIP;
						end
					end
					MODE_SKIP: begin
						skip_d = skip_q - 16'd1;
						if (skip_d == '0) mode_d = MODE_FF;
					end
					MODE_SOF: begin
						if (field_q == 4'd3 || field_q == 4'd4)
							height_d = {16'd0, height_q[7:0], b};
						else if (field_q == 4'd5 || field_q == 4'd6)
							width_d = {16'd0, width_q[7:0], b};
						if (field_q == 4'd6) begin
							emit_p = 1'b1;
							kind_p = KIND_JPEG;
							w_p    = width_d;
							h_p    = height_q;
						end else begin
							field_d = field_q + 4'd1;
						end
					end
					default: begin
						emit_p = 1'b1;
					end
				endcase
			end
		end
	end

	// a final byte with nothing decided still gives a none result
	always_comb begin
		result.valid      = emit_p || (item.last_byte && !decided_q);
		result.image_kind = kind_p;
		result.width      = w_p;
		result.height     = h_p;
		decided_d         = decided_q || emit_p;
		pos_d             = (pos_q < WINDOW_POS) ? pos_q + POS_W'(1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			mode_q    <= MODE_DETECT;
			skip_q    <= '0;
			len_hi_q  <= '0;
			width_q   <= '0;
			height_q  <= '0;
			field_q   <= '0;
			decided_q <= 1'b0;
		end else if (step_en) begin
			if (item.last_byte) begin
				pos_q     <= '0;
				mode_q    <= MODE_DETECT;
				skip_q    <= '0;
				len_hi_q  <= '0;
				width_q   <= '0;
				height_q  <= '0;
				field_q   <= '0;
				decided_q <= 1'b0;
			end else begin
				pos_q     <= pos_d;
				mode_q    <= mode_d;
				skip_q    <= skip_d;
				len_hi_q  <= len_hi_d;
				width_q   <= width_d;
				height_q  <= height_d;
				field_q   <= field_d;
				decided_q <= decided_d;
			end
		end
	end

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && emit_p) |-> !decided_q)
		else $error("second result for one file");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && result.valid && result.image_kind == KIND_NONE) |->
		(result.width == '0 && result.height == '0))
		else $error("kind none with nonzero dimensions");

	a_jpeg_16bit: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && result.valid && result.image_kind == KIND_JPEG) |->
		(result.width[31:16] == '0 && result.height[31:16] == '0))
		else $error("JPEG dimension above 16 bits");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && item.last_byte) |=> (!decided_q && pos_q == '0 && mode_q == MODE_DETECT))
		else $error("state not cleared after final byte");

endmodule

// ===== design/ihsp_out_reg.sv =====
// Result register: holds one result item until the downstream side takes it.
module ihsp_out_reg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  ihsp_pkg::result_t                    result,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [ihsp_pkg::OUT_TDATA_W-1:0]     out_data
);
	import ihsp_pkg::*;

	logic        valid_q;
	image_kind_t kind_q;
	logic [31:0] width_q;
	logic [31:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q   <= result.image_kind;
			width_q  <= result.width;
			height_q <= result.height;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), height_q, width_q, kind_q};

endmodule

// ===== design/image_header_size_parser.sv =====
// Top level of the image header size parser: input register, parser, result register.
//
// channel   dir  fields (lowest bit first)                       accepted when
// s_axis    in   tdata[7:0] data_byte, tlast last_byte            s_axis_tvalid && s_axis_tready
// m_axis    out  tdata[1:0] image_kind, [33:2] width, [65:34]    m_axis_tvalid && m_axis_tready
//                height, [71:66] zero
//
// One byte item per cycle while the input side is not stalled: a byte sits in the input
// register while the parser steps on it, and any result lands in the result register on
// the edge that ends that step. A result shows on m_axis once the deciding byte has passed
// the input register and the result register; the parser state update is the only loop.
// The input side stalls only while a result waits in the result register and
// m_axis_tready is low.
// Reset clears the parser state and both valid flags; one result per file, on the
// deciding byte or on the final byte.
module image_header_size_parser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [7:0]                       s_axis_tdata,  // data_byte
	input  logic                             s_axis_tlast,  // last_byte
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [ihsp_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // image_kind, width, height, pad
);
	import ihsp_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     valid_s1;
	logic     advance;
	logic     step_en;
	result_t  result;

	assign in_item.data_byte = s_axis_tdata;
	assign in_item.last_byte = s_axis_tlast;

	// advance the staged byte whenever the result register is free or draining
	assign advance = !m_axis_tvalid || m_axis_tready;
	assign step_en = valid_s1 && advance;

	ihsp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// step the header walk on the staged byte
	ihsp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.item   (item_s1),
		.result (result)
	);

	// load a result only for a byte that actually steps
	ihsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_en && result.valid),
		.result    (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule
